// ===== sv/ssp_pkg.sv =====
// shared types and constants for the shelf sprite placer
// no dependencies; imported by the interfaces, the placement core and the top level
package ssp_pkg;

    localparam int MAX_SIDE    = 4096;
    localparam int DIM_W       = 13;
    localparam int POS_W       = 12;
    localparam int RGBA_W      = 32;

    localparam logic [DIM_W-1:0] SHEET_RESET = DIM_W'(512);
    // largest side the sheet can have, clipped to what a 13-bit register can hold
    localparam logic [DIM_W-1:0] SIDE_CAP =
        (MAX_SIDE > (2 ** DIM_W - 1)) ? {DIM_W{1'b1}} : DIM_W'(MAX_SIDE);

    typedef struct packed {
        logic              start_of_sprite;
        logic [DIM_W-1:0]  spr_width;
        logic [DIM_W-1:0]  spr_height;
        logic [RGBA_W-1:0] pixel_rgba;
    } t_pixel_in;

    typedef struct packed {
        logic              non_square;
        logic              widths_differ;
        logic              overflowed;
    } t_flags;

    typedef struct packed {
        logic [POS_W-1:0]  dest_x;
        logic [POS_W-1:0]  dest_y;
        logic [RGBA_W-1:0] out_rgba;
        t_flags            flags;
    } t_pixel_out;

endpackage

// ===== sv/ssp_if.sv =====
// valid/ready channel interfaces for sprite pixels in and placed pixels out
// depends on ssp_pkg for field widths
interface ssp_in_if
    import ssp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              start_of_sprite;
    logic [DIM_W-1:0]  spr_width;
    logic [DIM_W-1:0]  spr_height;
    logic [RGBA_W-1:0] pixel_rgba;

    modport source (output valid, start_of_sprite, spr_width, spr_height, pixel_rgba,
                    input ready);
    modport sink   (input valid, start_of_sprite, spr_width, spr_height, pixel_rgba,
                    output ready);
endinterface

interface ssp_out_if
    import ssp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [POS_W-1:0]  dest_x;
    logic [POS_W-1:0]  dest_y;
    logic [RGBA_W-1:0] out_rgba;
    logic              overflowed;
    logic              widths_differ;
    logic              non_square;

    modport source (output valid, dest_x, dest_y, out_rgba, overflowed, widths_differ,
                    non_square, input ready);
    modport sink   (input valid, dest_x, dest_y, out_rgba, overflowed, widths_differ,
                    non_square, output ready);
endinterface

// ===== sv/ssp_place.sv =====
// placement core: cursor, shelf and sprite-local counters, sticky flags, sheet size
// depends on ssp_pkg; state advances on i_fire, result is combinational from state and pixel
module ssp_place
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data,
    input  logic             i_fire,
    input  t_pixel_in        i_pix,
    output logic             o_emit,
    output t_pixel_out       o_result
);

    logic [DIM_W-1:0] r_sheet_size;
    logic [DIM_W-1:0] r_cursor_x, n_cursor_x;
    logic [DIM_W-1:0] r_cursor_y, n_cursor_y;
    logic [DIM_W-1:0] r_row_tallest, n_row_tallest;
    logic [DIM_W-1:0] r_prev_width, n_prev_width;
    logic [DIM_W-1:0] r_place_x, n_place_x;
    logic [DIM_W-1:0] r_place_y, n_place_y;
    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    t_flags           r_flags, n_flags;

    logic [DIM_W-1:0] side, w, h, cx_place, px, py;
    logic [DIM_W:0]   sum_x, dx, x_next;
    logic [DIM_W+1:0] cy_try, cy_end;
    logic             wrap, ovf;
    logic [POS_W-1:0] x, y;
    logic             corner_x, corner_y;
    logic [DIM_W:0]   dy;

    always_comb begin
        side = (r_sheet_size > SIDE_CAP) ? SIDE_CAP : r_sheet_size;
        w    = (i_pix.spr_width  == '0) ? DIM_W'(1) : i_pix.spr_width;
        h    = (i_pix.spr_height == '0) ? DIM_W'(1) : i_pix.spr_height;

        // shelf placement for a start pixel
        sum_x  = {1'b0, r_cursor_x} + {1'b0, w};
        wrap   = sum_x > {1'b0, side};
        cy_try = wrap ? ({2'b0, r_cursor_y} + {2'b0, r_row_tallest}) : {2'b0, r_cursor_y};
        cy_end = cy_try + {2'b0, h};
        ovf    = cy_end > {2'b0, side};
        cx_place = wrap ? '0 : r_cursor_x;

        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_row_tallest = r_row_tallest;
        n_prev_width  = r_prev_width;
        n_place_x     = r_place_x;
        n_place_y     = r_place_y;
        n_flags       = r_flags;

        if (i_pix.start_of_sprite) begin
            n_cursor_x   = cx_place + w;
            n_cursor_y   = ovf ? '0 : cy_try[DIM_W-1:0];
            // a wrapped row starts with this sprite's height only
            n_row_tallest = (wrap || (h > r_row_tallest)) ? h : r_row_tallest;
            n_prev_width = w;
            n_place_x    = cx_place;
            n_place_y    = n_cursor_y;
            if ((r_prev_width != '0) && (r_prev_width != w)) n_flags.widths_differ = 1'b1;
            if (w != h) n_flags.non_square = 1'b1;
            if (ovf) n_flags.overflowed = 1'b1;
        end

        px = n_place_x;
        py = n_place_y;
        x  = i_pix.start_of_sprite ? '0 : r_col;
        y  = i_pix.start_of_sprite ? '0 : r_row;

        corner_x = (x == '0) || ({1'b0, x} == (w - DIM_W'(1)));
        corner_y = (y == '0) || ({1'b0, y} == (h - DIM_W'(1)));
        dx = {1'b0, px} + {2'b0, x};
        dy = {1'b0, py} + {2'b0, y};

        o_emit = !(corner_x && corner_y) && (dx < {1'b0, side}) && (dy < {1'b0, side});
        o_result.dest_x   = dx[POS_W-1:0];
        o_result.dest_y   = dy[POS_W-1:0];
        o_result.out_rgba = i_pix.pixel_rgba;
        o_result.flags    = n_flags;

        // step through the sprite in raster order
        x_next = {2'b0, x} + (DIM_W+1)'(1);
        if ((x_next >= {1'b0, w}) || (x == {POS_W{1'b1}})) begin
            n_col = '0;
            n_row = y + POS_W'(1);
        end else begin
            n_col = x_next[POS_W-1:0];
            n_row = y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sheet_size  <= SHEET_RESET;
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_row_tallest <= '0;
            r_prev_width  <= '0;
            r_place_x     <= '0;
            r_place_y     <= '0;
            r_col         <= '0;
            r_row         <= '0;
            r_flags       <= '0;
        end else begin
            if (i_cfg_we) r_sheet_size <= i_cfg_data;
            if (i_fire) begin
                r_cursor_x    <= n_cursor_x;
                r_cursor_y    <= n_cursor_y;
                r_row_tallest <= n_row_tallest;
                r_prev_width  <= n_prev_width;
                r_place_x     <= n_place_x;
                r_place_y     <= n_place_y;
                r_col         <= n_col;
                r_row         <= n_row;
                r_flags       <= n_flags;
            end
        end
    end

endmodule

// ===== sv/shelf_sprite_placer_top.sv =====
// top level of the shelf sprite placer: input stage, placement core, output register
// depends on ssp_pkg, ssp_in_if / ssp_out_if and ssp_place
//
// Sprite pixels enter on i_pix in raster order, one per transfer; the first pixel of
// each sprite carries start_of_sprite together with the sprite's width and height.
// Placed pixels leave on o_pix with their sheet column and row, the colour unchanged
// and the three sticky flags as they stand after that pixel. Corner pixels of each
// sprite and pixels that land outside the sheet produce no output transfer.
// i_cfg_we / i_cfg_data write the sheet side; write it only while nothing is in flight.
// An accepted pixel is registered in the input stage and then in the output register
// before it is shown on o_pix. Throughput: one pixel per cycle while the receiver does
// not stall, set by the update of the cursor and sprite counters in the placement core.
// Reset (synchronous, active low) clears cursor, shelf, counters and flags, sets the
// sheet side to 512 and empties both stages.
// When the receiver stalls, the output register holds its pixel; one more pixel waits
// in the input stage, and i_pix.ready drops once that pixel also needs the output.
module shelf_sprite_placer_top
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data,
    ssp_in_if.sink           i_pix,
    ssp_out_if.source        o_pix
);

    logic       r_s1_valid;
    t_pixel_in  r_s1;
    logic       r_out_valid;
    t_pixel_out r_out;

    logic       emit;
    logic       fire;
    logic       in_ready;
    t_pixel_out result;

    ssp_place u_place (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_fire     (fire),
        .i_pix      (r_s1),
        .o_emit     (emit),
        .o_result   (result)
    );

    // a dropped pixel never needs the output register
    assign fire     = r_s1_valid && (!emit || !r_out_valid || o_pix.ready);
    assign in_ready = !r_s1_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_ready) r_s1_valid <= i_pix.valid;
            if (fire && emit) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_pix.valid) begin
            r_s1.start_of_sprite <= i_pix.start_of_sprite;
            r_s1.spr_width       <= i_pix.spr_width;
            r_s1.spr_height      <= i_pix.spr_height;
            r_s1.pixel_rgba      <= i_pix.pixel_rgba;
        end
        if (fire && emit) r_out <= result;
    end

    assign i_pix.ready         = in_ready;
    assign o_pix.valid         = r_out_valid;
    assign o_pix.dest_x        = r_out.dest_x;
    assign o_pix.dest_y        = r_out.dest_y;
    assign o_pix.out_rgba      = r_out.out_rgba;
    assign o_pix.overflowed    = r_out.flags.overflowed;
    assign o_pix.widths_differ = r_out.flags.widths_differ;
    assign o_pix.non_square    = r_out.flags.non_square;

endmodule

// ===== sv/ssp_checker.sv =====
// port-level checks for the shelf sprite placer, bound to the top level
// depends on ssp_pkg for field widths
module ssp_checker
    import ssp_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [POS_W-1:0]  i_dest_x,
    input logic [POS_W-1:0]  i_dest_y,
    input logic [RGBA_W-1:0] i_out_rgba,
    input logic              i_overflowed,
    input logic              i_widths_differ,
    input logic              i_non_square
);

    logic r_any_in;
    logic r_seen_ovf;
    logic r_seen_wd;
    logic r_seen_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_any_in   <= 1'b0;
            r_seen_ovf <= 1'b0;
            r_seen_wd  <= 1'b0;
            r_seen_ns  <= 1'b0;
        end else begin
            if (i_in_valid && i_in_ready) r_any_in <= 1'b1;
            if (i_out_valid && i_out_ready) begin
                if (i_overflowed)    r_seen_ovf <= 1'b1;
                if (i_widths_differ) r_seen_wd  <= 1'b1;
                if (i_non_square)    r_seen_ns  <= 1'b1;
            end
        end
    end

    // output register is empty straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    // nothing comes out before the first pixel transfer in
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_any_in)
        else $error("output transfer without any input");

    // sticky flags never fall once shown
    a_sticky_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && r_seen_ovf) |-> i_overflowed)
        else $error("overflowed flag cleared");

    a_sticky_other: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((!r_seen_wd || i_widths_differ) && (!r_seen_ns || i_non_square)))
        else $error("widths_differ or non_square flag cleared");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_dest_x) && $stable(i_dest_y) && $stable(i_out_rgba)))
        else $error("stalled output changed");

endmodule

bind shelf_sprite_placer_top ssp_checker u_ssp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_pix.valid),
    .i_in_ready      (i_pix.ready),
    .i_out_valid     (o_pix.valid),
    .i_out_ready     (o_pix.ready),
    .i_dest_x        (o_pix.dest_x),
    .i_dest_y        (o_pix.dest_y),
    .i_out_rgba      (o_pix.out_rgba),
    .i_overflowed    (o_pix.overflowed),
    .i_widths_differ (o_pix.widths_differ),
    .i_non_square    (o_pix.non_square)
);

// ===== tb/ssp_pixel_checker.sv =====
// checker for the shelf sprite placer: watches both pixel channels and the sheet-side write
// port, predicts each placed pixel and compares it field by field; depends on ssp_pkg, ssp_if
`timescale 1ns / 1ps

module ssp_pixel_checker
    import ssp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [DIM_W-1:0] i_cfg_data,
    ssp_in_if                i_pix_in,
    ssp_out_if               i_pix_out,
    output int               o_fail_count,
    output int               o_pending
);

    localparam int PRINT_CAP = 200;

    logic [DIM_W-1:0] sheet_side;
    logic [DIM_W-1:0] cur_x;
    logic [DIM_W-1:0] cur_y;
    logic [DIM_W-1:0] shelf_height;
    logic [DIM_W-1:0] last_width;
    logic [DIM_W-1:0] origin_x;
    logic [DIM_W-1:0] origin_y;
    logic [POS_W-1:0] col_idx;
    logic [POS_W-1:0] row_idx;
    t_flags           flags;

    t_pixel_out       expected_placements[$];
    int               mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    task automatic report(input string msg);
        // keep the log short on a badly broken build
        if (mismatch_count < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic clear_placement();
        sheet_side   = SHEET_RESET;
        cur_x        = '0;
        cur_y        = '0;
        shelf_height = '0;
        last_width   = '0;
        origin_x     = '0;
        origin_y     = '0;
        col_idx      = '0;
        row_idx      = '0;
        flags        = '0;
        expected_placements.delete();
    endtask

    task automatic predict_placement(input t_pixel_in px);
        int unsigned side, w, h, x, y, dx, dy, next_y;
        logic        corner_x, corner_y;
        t_pixel_out  res;
        side = (sheet_side > MAX_SIDE) ? MAX_SIDE : sheet_side;
        w = (px.spr_width == 0) ? 1 : px.spr_width;
        h = (px.spr_height == 0) ? 1 : px.spr_height;

        if (px.start_of_sprite) begin
            if (last_width != 0 && last_width != w) flags.widths_differ = 1'b1;
            if (w != h) flags.non_square = 1'b1;
            next_y = cur_y;
            // no room left on this shelf: start a new one under the finished row
            if (cur_x + w > side) begin
                cur_x        = '0;
                next_y       = cur_y + shelf_height;
                shelf_height = DIM_W'(h);
            end else if (h > shelf_height) begin
                shelf_height = DIM_W'(h);
            end
            if (next_y + h > side) begin
                next_y         = 0;
                flags.overflowed = 1'b1;
            end
            cur_y      = DIM_W'(next_y);
            origin_x   = cur_x;
            origin_y   = cur_y;
            cur_x      = DIM_W'(cur_x + w);
            last_width = DIM_W'(w);
            col_idx    = '0;
            row_idx    = '0;
        end

        x = col_idx;
        y = row_idx;
        corner_x = (x == 0) || (x == w - 1);
        corner_y = (y == 0) || (y == h - 1);
        dx = origin_x + x;
        dy = origin_y + y;

        if (x + 1 >= w || col_idx == {POS_W{1'b1}}) begin
            col_idx = '0;
            row_idx = row_idx + 1'b1;
        end else begin
            col_idx = POS_W'(x + 1);
        end

        if (!(corner_x && corner_y) && dx < side && dy < side) begin
            res.dest_x   = POS_W'(dx);
            res.dest_y   = POS_W'(dy);
            res.out_rgba = px.pixel_rgba;
            res.flags    = flags;
            expected_placements.push_back(res);
        end
    endtask

    task automatic check_placement();
        t_pixel_out want;
        if (expected_placements.size() == 0) begin
            report($sformatf("unexpected pixel at (%0d,%0d) rgba %08h", i_pix_out.dest_x,
                             i_pix_out.dest_y, i_pix_out.out_rgba));
            return;
        end
        want = expected_placements.pop_front();
        if (i_pix_out.dest_x !== want.dest_x)
            report($sformatf("dest_x expected %0d, got %0d", want.dest_x, i_pix_out.dest_x));
        if (i_pix_out.dest_y !== want.dest_y)
            report($sformatf("dest_y expected %0d, got %0d", want.dest_y, i_pix_out.dest_y));
        if (i_pix_out.out_rgba !== want.out_rgba)
            report($sformatf("out_rgba expected %08h, got %08h", want.out_rgba,
                             i_pix_out.out_rgba));
        if (i_pix_out.overflowed !== want.flags.overflowed)
            report($sformatf("overflowed expected %0b, got %0b", want.flags.overflowed,
                             i_pix_out.overflowed));
        if (i_pix_out.widths_differ !== want.flags.widths_differ)
            report($sformatf("widths_differ expected %0b, got %0b", want.flags.widths_differ,
                             i_pix_out.widths_differ));
        if (i_pix_out.non_square !== want.flags.non_square)
            report($sformatf("non_square expected %0b, got %0b", want.flags.non_square,
                             i_pix_out.non_square));
    endtask

    always @(posedge i_clk) begin
        t_pixel_in px;
        if (!i_rst_n) begin
            clear_placement();
        end else begin
            if (i_pix_out.valid && i_pix_out.ready) check_placement();
            if (i_pix_in.valid && i_pix_in.ready) begin
                px.start_of_sprite = i_pix_in.start_of_sprite;
                px.spr_width       = i_pix_in.spr_width;
                px.spr_height      = i_pix_in.spr_height;
                px.pixel_rgba      = i_pix_in.pixel_rgba;
                predict_placement(px);
            end
            if (i_cfg_we) sheet_side = i_cfg_data;
        end
        o_pending <= expected_placements.size();
    end

endmodule

// ===== tb/testbench.sv =====
// top of the shelf sprite placer testbench: clock, reset, pixel stimulus, output stalls
// and the verdict; depends on ssp_pkg, ssp_if, shelf_sprite_placer_top and ssp_pixel_checker
`timescale 1ns / 1ps

module testbench;
    import ssp_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [DIM_W-1:0] i_cfg_data;

    logic             tx_burst = 1'b0;
    logic             rx_burst = 1'b0;
    logic             rx_hold  = 1'b0;
    logic             hold_go  = 1'b0;
    int unsigned      pixels_sent = 0;
    int               cycle_count = 0;
    int               fail_count;
    int               pending;

    ssp_in_if  pix_in_if ();
    ssp_out_if pix_out_if ();

    shelf_sprite_placer_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_in_if),
        .o_pix      (pix_out_if)
    );

    ssp_pixel_checker placement_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_pix_in     (pix_in_if),
        .i_pix_out    (pix_out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_pixel(input logic sos, input int unsigned w, input int unsigned h,
                              input logic [RGBA_W-1:0] rgba);
        int unsigned gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            pix_in_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_in_if.valid           <= 1'b1;
        pix_in_if.start_of_sprite <= sos;
        pix_in_if.spr_width       <= DIM_W'(w);
        pix_in_if.spr_height      <= DIM_W'(h);
        pix_in_if.pixel_rgba      <= rgba;
        do @(posedge i_clk); while (!pix_in_if.ready);
        pixels_sent++;
    endtask

    task automatic send_sprite(input int unsigned w, input int unsigned h,
                               input int unsigned count);
        send_pixel(1'b1, w, h, $urandom());
        repeat (count - 1) send_pixel(1'b0, w, h, $urandom());
    endtask

    // dropped pixels leave no trace in the checker, so allow for the pipeline afterwards
    task automatic wait_idle();
        pix_in_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_sheet(input int unsigned side);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= DIM_W'(side);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic scatter_sprites(input int unsigned n_pixels);
        int unsigned stop_at, kind, w, h, count;
        stop_at = pixels_sent + n_pixels;
        while (pixels_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                w = $urandom_range(1, 10);
                h = ($urandom_range(0, 1) == 0) ? w : $urandom_range(1, 10);
                count = w * h;
                // now and then a sprite cut short or running past its last row
                if ($urandom_range(0, 7) == 0) count = $urandom_range(1, count + w);
                send_sprite(w, h, count);
            end else if (kind == 8) begin
                send_sprite($urandom_range(0, 8191), $urandom_range(0, 8191),
                            $urandom_range(1, 6));
            end else begin
                repeat ($urandom_range(1, 4))
                    send_pixel(1'b0, $urandom_range(0, 8191), $urandom_range(0, 8191),
                               $urandom());
            end
        end
    endtask

    initial begin : receiver
        int unsigned pause;
        pix_out_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            pause = rx_burst ? 0 : $urandom_range(0, 19);
            if (pause != 0 || rx_hold) begin
                pix_out_if.ready <= 1'b0;
                repeat (pause) @(posedge i_clk);
                while (rx_hold) @(posedge i_clk);
            end
            pix_out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!pix_out_if.valid);
        end
    end

    // long output stall while the sender keeps going, so the block backs up
    initial begin : long_stall
        wait (hold_go);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (300) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    initial begin : stimulus
        i_rst_n                   <= 1'b0;
        i_cfg_we                  <= 1'b0;
        i_cfg_data                <= '0;
        pix_in_if.valid           <= 1'b0;
        pix_in_if.start_of_sprite <= 1'b0;
        pix_in_if.spr_width       <= '0;
        pix_in_if.spr_height      <= '0;
        pix_in_if.pixel_rgba      <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sheet at its reset side of 512
        send_pixel(1'b0, 3, 3, $urandom());     // before any sprite, corner
        send_pixel(1'b0, 3, 3, '1);
        send_sprite(3, 3, 9);                   // square, flags still clear
        send_pixel(1'b1, 0, 0, $urandom());     // zero size counts as 1x1
        send_pixel(1'b0, 0, 0, '0);             // below the sprite's last row
        send_sprite(2, 1, 3);                   // not square
        send_sprite(4096, 2, 3);                // wider than the sheet
        send_sprite(8191, 8191, 2);             // runs off the bottom

        // largest sheet the block can use
        write_sheet(4096);
        scatter_sprites(200);

        write_sheet(1);
        scatter_sprites(40);
        write_sheet(0);
        scatter_sprites(40);
        write_sheet(8191);
        scatter_sprites(100);
        write_sheet(13);
        scatter_sprites(250);

        write_sheet(32);
        tx_burst = 1'b1;
        rx_burst <= 1'b1;
        hold_go  <= 1'b1;
        scatter_sprites(250);
        tx_burst = 1'b0;
        rx_burst <= 1'b0;

        write_sheet(64);
        scatter_sprites(200);
        write_sheet(512);
        scatter_sprites(200);
        write_sheet($urandom_range(1, 4096));
        scatter_sprites(150);
        write_sheet($urandom_range(2, 40));
        scatter_sprites(150);

        wait_idle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== shelf_sprite_placer_top.f =====
sv/ssp_pkg.sv
sv/ssp_if.sv
sv/ssp_place.sv
sv/shelf_sprite_placer_top.sv
sv/ssp_checker.sv
tb/ssp_pixel_checker.sv
tb/testbench.sv
